### src/tepc_pkg.sv
`default_nettype none

package tepc_pkg;

  // one pattern cell as held in the column memory
  typedef struct packed {
    logic [7:0] note;
    logic [8:0] instrument;
    logic [1:0] vkind;
    logic [7:0] vvalue;
    logic [4:0] effect;
    logic [7:0] evalue;
  } cell_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // event command bytes
  localparam logic [7:0] CMD_DUP    = 8'h7F;
  localparam logic [7:0] CMD_INSTR  = 8'h80;
  localparam logic [7:0] CMD_VOLUME = 8'h83;

  // volume column kinds
  localparam logic [1:0] VK_NONE = 2'd0;
  localparam logic [1:0] VK_VOL  = 2'd1;
  localparam logic [1:0] VK_PAN  = 2'd2;

  // source effect numbers (command byte with the top bit dropped)
  localparam logic [6:0] SFX_SPEED      = 7'h01;
  localparam logic [6:0] SFX_VOLSLIDE   = 7'h02;
  localparam logic [6:0] SFX_PORTA      = 7'h04;
  localparam logic [6:0] SFX_TPORTA     = 7'h06;
  localparam logic [6:0] SFX_TREMOR     = 7'h07;
  localparam logic [6:0] SFX_ARPEGGIO   = 7'h08;
  localparam logic [6:0] SFX_VIBRATO    = 7'h09;
  localparam logic [6:0] SFX_TPORTA_VOL = 7'h0A;
  localparam logic [6:0] SFX_VIB_VOL    = 7'h0B;
  localparam logic [6:0] SFX_BREAK      = 7'h0C;
  localparam logic [6:0] SFX_JUMP       = 7'h0D;
  localparam logic [6:0] SFX_RETRIG     = 7'h0F;
  localparam logic [6:0] SFX_OFFSET     = 7'h10;
  localparam logic [6:0] SFX_FINE_VOL   = 7'h11;
  localparam logic [6:0] SFX_FINE_PORTA = 7'h12;
  localparam logic [6:0] SFX_NOTE_DELAY = 7'h13;
  localparam logic [6:0] SFX_NOTE_CUT   = 7'h14;
  localparam logic [6:0] SFX_TEMPO      = 7'h15;
  localparam logic [6:0] SFX_XFINE_PORTA = 7'h16;
  localparam logic [6:0] SFX_PANNING    = 7'h17;

  // dense output effect codes
  localparam logic [4:0] EFX_NONE       = 5'd0;
  localparam logic [4:0] EFX_SPEED      = 5'd1;
  localparam logic [4:0] EFX_VOLSLIDE   = 5'd2;
  localparam logic [4:0] EFX_TPORTA_VOL = 5'd3;
  localparam logic [4:0] EFX_VIB_VOL    = 5'd4;
  localparam logic [4:0] EFX_PORTA_UP   = 5'd5;
  localparam logic [4:0] EFX_PORTA_DOWN = 5'd6;
  localparam logic [4:0] EFX_TPORTA     = 5'd7;
  localparam logic [4:0] EFX_TREMOR     = 5'd8;
  localparam logic [4:0] EFX_ARPEGGIO   = 5'd9;
  localparam logic [4:0] EFX_VIBRATO    = 5'd10;
  localparam logic [4:0] EFX_BREAK      = 5'd11;
  localparam logic [4:0] EFX_JUMP       = 5'd12;
  localparam logic [4:0] EFX_RETRIG     = 5'd13;
  localparam logic [4:0] EFX_OFFSET     = 5'd14;
  localparam logic [4:0] EFX_EXTENDED   = 5'd15;
  localparam logic [4:0] EFX_TEMPO      = 5'd16;
  localparam logic [4:0] EFX_PANNING    = 5'd17;

  // parameter nibble prefixes
  localparam logic [3:0] NIB_XFINE = 4'hE;
  localparam logic [3:0] NIB_FINE  = 4'hF;
  localparam logic [3:0] NIB_DELAY = 4'hD;
  localparam logic [3:0] NIB_CUT   = 4'hC;
  localparam logic [7:0] PAN_BIAS  = 8'd64;

  // translate one effect command into the cell
  function automatic cell_t apply_effect(cell_t c, logic [6:0] code, logic [7:0] p);
    cell_t      r;
    logic [4:0] fx;
    logic [7:0] v;
    logic [7:0] np;
    logic [7:0] pan;
    logic [3:0] pre;
    r   = c;
    fx  = EFX_NONE;
    v   = p;
    np  = 8'(8'h00 - p);
    pan = {1'b0, 7'(p + PAN_BIAS)};
    pre = (code == SFX_XFINE_PORTA) ? NIB_XFINE : NIB_FINE;
    unique case (code)
      SFX_SPEED: fx = EFX_SPEED;
      SFX_VOLSLIDE, SFX_TPORTA_VOL, SFX_VIB_VOL: begin
        fx = (code == SFX_VOLSLIDE) ? EFX_VOLSLIDE :
             (code == SFX_TPORTA_VOL) ? EFX_TPORTA_VOL : EFX_VIB_VOL;
        v  = p[7] ? {4'h0, np[3:0]} : {p[3:0], 4'h0};
      end
      SFX_PORTA: begin
        if (p[7]) begin
          fx = EFX_PORTA_UP;
          v  = np;
        end else begin
          fx = EFX_PORTA_DOWN;
        end
      end
      SFX_TPORTA:   fx = EFX_TPORTA;
      SFX_TREMOR:   fx = EFX_TREMOR;
      SFX_ARPEGGIO: fx = EFX_ARPEGGIO;
      SFX_VIBRATO:  fx = EFX_VIBRATO;
      SFX_BREAK:    fx = EFX_BREAK;
      SFX_JUMP:     fx = EFX_JUMP;
      SFX_RETRIG:   fx = EFX_RETRIG;
      SFX_OFFSET:   fx = EFX_OFFSET;
      SFX_FINE_VOL: begin
        if (p != 8'h00) begin
          fx = EFX_VOLSLIDE;
          v  = p[7] ? {NIB_FINE, np[3:0]} : {p[3:0], NIB_FINE};
        end
      end
      SFX_FINE_PORTA, SFX_XFINE_PORTA: begin
        if (p != 8'h00) begin
          if (p[7]) begin
            fx = EFX_PORTA_UP;
            v  = {pre, np[3:0]};
          end else begin
            fx = EFX_PORTA_DOWN;
            v  = p | {pre, 4'h0};
          end
        end
      end
      SFX_NOTE_DELAY: begin
        fx = EFX_EXTENDED;
        v  = {NIB_DELAY, p[3:0]};
      end
      SFX_NOTE_CUT: begin
        fx = EFX_EXTENDED;
        v  = {NIB_CUT, p[3:0]};
      end
      SFX_TEMPO: fx = EFX_TEMPO;
      SFX_PANNING: begin
        v = pan;
        if (c.effect != EFX_NONE) begin
          if (c.vkind == VK_NONE) begin
            r.vkind  = VK_PAN;
            r.vvalue = {1'b0, pan[7:1]};
          end
        end else begin
          fx = EFX_PANNING;
        end
      end
      default: fx = EFX_NONE;
    endcase
    if (fx != EFX_NONE) begin
      r.effect = fx;
      r.evalue = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/tepc_ctrl.sv
`default_nettype none

module tepc_ctrl import tepc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output      logic       s_tready,
  input  wire dp_status_t status,
  output      ctrl_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait for room in the output register
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == ST_EXEC) && !s_tready)
    else $error("no execute step after accept");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) && !status.out_free |=> (state == ST_EXEC))
    else $error("left execute step with output full");

endmodule

`default_nettype wire

### src/tepc_datapath.sv
`default_nettype none

module tepc_datapath import tepc_pkg::*; #(
  parameter int MAX_ROWS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  output      dp_status_t  status,
  input  wire logic        cfg_valid,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        s_tuser,
  input  wire logic [23:0] s_tdata,
  input  wire logic        m_tready,
  output      logic        m_tvalid,
  output      logic [47:0] m_tdata,
  output      logic        m_tuser
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam logic [8:0] MaxRowsW = 9'(MAX_ROWS);

  cell_t mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] valid;

  logic [8:0] rows_in_use;
  logic       stopped;
  logic [8:0] last_instr;

  logic [7:0] row_q;
  logic [7:0] cmd_q;
  logic [7:0] arg_q;
  logic       ignore_q;
  cell_t      rd_data;
  logic       rd_valid_q;

  logic        start;
  logic [7:0]  in_row;
  logic [7:0]  in_cmd;
  logic [7:0]  in_arg;
  logic [8:0]  row_limit;
  logic        stop_now;
  logic [9:0]  src;
  logic        src_ok;
  logic [AW-1:0] rd_addr;
  cell_t       cur;
  cell_t       new_cell;
  cell_t       out_cell;

  assign start  = s_tuser;
  assign in_row = s_tdata[7:0];
  assign in_cmd = s_tdata[15:8];
  assign in_arg = s_tdata[23:16];

  // accept side: limit check and read address
  always_comb begin
    row_limit = (rows_in_use > MaxRowsW) ? MaxRowsW : rows_in_use;
    stop_now  = (!start && stopped) || ({1'b0, in_row} >= row_limit);
    src       = {2'b00, in_row} + {{2{in_arg[7]}}, in_arg};
    src_ok    = !src[9] && (src[8:0] < row_limit);
    rd_addr   = ((in_cmd == CMD_DUP) && src_ok) ? src[AW-1:0] : in_row[AW-1:0];
  end

  // execute side: update the cell that was read
  always_comb begin
    cur      = rd_valid_q ? rd_data : '0;
    new_cell = cur;
    priority if (cmd_q < CMD_DUP) begin
      new_cell.note = 8'(cmd_q + 8'd1);
      if (cur.instrument == 9'd0) begin
        new_cell.instrument = last_instr;
      end
      new_cell.vkind  = VK_VOL;
      new_cell.vvalue = arg_q;
    end else if (cmd_q == CMD_DUP) begin
      // source cell, or own cell when the source is out of range
      new_cell = cur;
    end else if (cmd_q == CMD_INSTR) begin
      new_cell.instrument = {1'b0, arg_q} + 9'd1;
    end else if (cmd_q == CMD_VOLUME) begin
      new_cell.vkind  = VK_VOL;
      new_cell.vvalue = arg_q;
    end else begin
      new_cell = apply_effect(cur, cmd_q[6:0], arg_q);
    end
    out_cell = ignore_q ? '0 : new_cell;
  end

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data    <= mem[rd_addr];
      rd_valid_q <= !start && valid[rd_addr];
      row_q      <= in_row;
      cmd_q      <= in_cmd;
      arg_q      <= in_arg;
      ignore_q   <= stop_now;
    end
    if (cmd.commit && !ignore_q) begin
      mem[row_q[AW-1:0]] <= new_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 9'd64;
      stopped     <= 1'b0;
      last_instr  <= '0;
      valid       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        rows_in_use <= cfg_data;
      end
      if (cmd.accept) begin
        if (start) begin
          valid      <= '0;
          last_instr <= '0;
        end
        stopped <= stop_now;
      end
      if (cmd.commit && !ignore_q) begin
        valid[row_q[AW-1:0]] <= 1'b1;
        if (cmd_q == CMD_INSTR) begin
          last_instr <= new_cell.instrument;
        end
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tuser <= !ignore_q;
      m_tdata <= {out_cell.evalue, out_cell.effect, out_cell.vvalue, out_cell.vkind,
                  out_cell.instrument, out_cell.note, row_q};
    end
  end

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("result not presented after commit");

  a_ignored_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[47:8] == 40'd0))
    else $error("ignored event carries cell data");

  a_codes_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[26:25] != 2'd3) && (m_tdata[39:35] <= EFX_PANNING))
    else $error("illegal volume kind or effect code");

endmodule

`default_nettype wire

### src/track_event_to_pattern_cell.sv
// channel  dir  handshake               payload
// s_       in   s_tvalid / s_tready     tuser: track_start; tdata: row, command, argument
// m_       out  m_tvalid / m_tready     tuser: accepted; tdata: row and cell fields
// cfg_     in   cfg_valid / cfg_ready   cfg_data: rows_in_use
//
// each word goes through an accept step (limit check, one read of the cell memory),
// then an execute step (cell update, write back, load of the output register)
// the cell memory has a single read/write port, used for the read in accept and the write in execute
// execute waits while the output register still holds a word not yet taken
// reset clears cell valid bits, last instrument, stop flag and sets rows_in_use to 64
// cfg_ready is always high; writes are expected only while the block is idle
`default_nettype none

module track_event_to_pattern_cell import tepc_pkg::*; #(
  parameter int MAX_ROWS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,  // event_row, event_command, event_argument
  input  wire logic        s_tuser,  // track_start
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // cell_row, cell_note, cell_instrument, volume_kind, volume_value,
  // effect_code, effect_value
  output      logic [47:0] m_tdata,
  output      logic        m_tuser,  // accepted
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [8:0]  cfg_data  // rows_in_use
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // register port never stalls
  assign cfg_ready = 1'b1;

  tepc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // cell memory, stop and instrument state, output register
  tepc_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire
